// ===== hw/rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants, codes and bit-order helpers of the bit stream packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int VAL_W           = 64;
	localparam int CNT_W           = 7;
	localparam int POS_W           = 16;
	localparam int WIN_W           = 80;
	localparam int MAX_CODE_BITS   = 65;

	localparam logic [2:0] OP_WRITE    = 3'd0;
	localparam logic [2:0] OP_READ     = 3'd1;
	localparam logic [2:0] OP_WRITE_C  = 3'd2;
	localparam logic [2:0] OP_READ_C   = 3'd3;
	localparam logic [2:0] OP_REWIND   = 3'd4;
	localparam logic [2:0] OP_CLEAR    = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_BADCOUNT = 2'd3;

	// Little-endian value of n bits to an MSB-first stream, left-aligned.
	function automatic logic [63:0] pack_slots(input logic [63:0] v, input logic [6:0] n);
		logic [63:0] s;
		logic [7:0]  b;
		logic [3:0]  full;
		logic [2:0]  r;
		full = n[6:3];
		r    = n[2:0];
		s    = '0;
		for (int i = 0; i < 8; i++) begin
			b = v[8*i +: 8];
			if (4'(i) < full)
				s[63-8*i -: 8] = b;
			else if (4'(i) == full && r != 3'd0)
				s[63-8*i -: 8] = b << (~r + 3'd1);
		end
		return s;
	endfunction

	// Left-aligned MSB-first stream of n bits back to a little-endian value.
	function automatic logic [63:0] unpack_slots(input logic [63:0] s, input logic [6:0] n);
		logic [63:0] v;
		logic [7:0]  b;
		logic [3:0]  full;
		logic [2:0]  r;
		full = n[6:3];
		r    = n[2:0];
		v    = '0;
		for (int i = 0; i < 8; i++) begin
			b = s[63-8*i -: 8];
			if (4'(i) < full)
				v[8*i +: 8] = b;
			else if (4'(i) == full && r != 3'd0)
				v[8*i +: 8] = b >> (~r + 3'd1);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bsp_ram.sv =====
// ----------------------------------------------------------------------------
// bsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bit_stream_packer_core.sv =====
// ----------------------------------------------------------------------------
// bit_stream_packer_core
// Bit-addressed byte store with write and read bit pointers, plain and
// compressed-integer writes and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command: operation, bit_count,
//   payload, unsigned_mode. Output channel (out_valid/out_ready) returns one
//   result per command: read_value, status and both pointers after it.
//   One command is worked at a time. A write passes through PREP, one WBYTE
//   step per store byte touched and DONE; a read through PREP, one RBYTE
//   step per store byte touched, ALIGN, DECODE and DONE. A command touches up
//   to 9 store bytes, plain or compressed; other commands, and commands that
//   fail their checks, go from PREP straight to DONE. The input is ready
//   again in the cycle the result is raised. The store moves one byte per
//   cycle through its single read and single write port.
//   The result sits in an output register, so the next command can be taken
//   while the receiver stalls; that command then holds its result until the
//   output register frees.
//   Reset clears both pointers and the output valid; store contents are left
//   undefined and are never read before written, since reads stop at the
//   write pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_stream_packer_core #(
	parameter int STORE_BYTES = bsp_pkg::STORE_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  operation,
	input  wire logic [bsp_pkg::CNT_W-1:0]   bit_count,
	input  wire logic [bsp_pkg::VAL_W-1:0]   payload,
	input  wire logic                        unsigned_mode,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [bsp_pkg::VAL_W-1:0]   read_value,
	output logic      [1:0]                  status,
	output logic      [bsp_pkg::POS_W-1:0]   write_position,
	output logic      [bsp_pkg::POS_W-1:0]   read_position
);

	import bsp_pkg::*;

	localparam int PTR_W = $clog2(STORE_BYTES * 8 + 1);
	localparam int AW    = $clog2(STORE_BYTES);
	localparam logic [PTR_W:0] CAP_BITS = (PTR_W+1)'(STORE_BYTES * 8);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_WBYTE  = 3'd2;
	localparam logic [2:0] S_RBYTE  = 3'd3;
	localparam logic [2:0] S_ALIGN  = 3'd4;
	localparam logic [2:0] S_DECODE = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]       state_q;
	logic [PTR_W-1:0] wptr_q, rptr_q, gptr_q;
	logic             out_valid_q;

	logic [2:0]       op_q;
	logic [6:0]       cnt_q;
	logic [63:0]      pay_q;
	logic             uns_q;
	logic [79:0]      stream_q, acc_q, lwin_q;
	logic [6:0]       rem_q, grem_q, gcnt_q;
	logic [63:0]      res_val_q;
	logic [1:0]       res_st_q;
	logic [63:0]      out_val_q;
	logic [1:0]       out_st_q;
	logic [POS_W-1:0] out_wpos_q, out_rpos_q;

	// command checks
	logic             plain_ok, comp_ok, is_wr, fits, short_plain;
	logic [3:0]       nb;
	logic [7:0]       mbyte;
	logic [3:0]       mnib;
	logic [PTR_W-1:0] avail;
	logic [6:0]       gsz;
	logic [1:0]       prep_st;

	// compressed encode
	logic [2:0]       cj, ck, kk;
	logic             crun, cterm, cflag;
	logic [63:0]      cbody;
	logic [6:0]       clen;
	logic [79:0]      cstream;
	logic [79:0]      wstream;
	logic [6:0]       wlen;

	// store write step
	logic [2:0]       woff;
	logic [3:0]       wroom, wtake, wend;
	logic [7:0]       wold, wbits, wmask, wmerged;

	// store read step
	logic [2:0]       goff;
	logic [3:0]       groom, gtake;
	logic [7:0]       gt8, gbits;

	// compressed decode
	logic [2:0]       dj, dk;
	logic             drun, dterm, dflag, dok;
	logic [79:0]      dbody;
	logic [63:0]      dval;
	logic [6:0]       dlen;

	logic             ram_re, ram_we;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;
	logic             done_go;

	assign in_ready = (state_q == S_IDLE);
	assign done_go  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		plain_ok    = (cnt_q >= 7'd1) && (cnt_q <= 7'd64);
		comp_ok     = (cnt_q >= 7'd8) && (cnt_q <= 7'd64) && (cnt_q[2:0] == 3'd0);
		is_wr       = (op_q == OP_WRITE) || (op_q == OP_WRITE_C);
		nb          = cnt_q[6:3];
		mbyte       = uns_q ? 8'h00 : 8'hFF;
		mnib        = uns_q ? 4'h0 : 4'hF;
		avail       = wptr_q - rptr_q;
		short_plain = PTR_W'(cnt_q) > avail;
		gsz         = (avail >= PTR_W'(MAX_CODE_BITS)) ? 7'(MAX_CODE_BITS) : avail[6:0];
	end

	// Count elided upper bytes, code MSB-first, pick the write stream.
	always_comb begin
		cj   = '0;
		crun = 1'b1;
		kk   = '0;
		for (int q = 0; q < 7; q++) begin
			kk = 3'(nb - 4'd1 - 4'(q));
			if (crun && (4'(q) < nb - 4'd1) && (pay_q[8*kk +: 8] == mbyte))
				cj = cj + 3'd1;
			else
				crun = 1'b0;
		end
		ck    = 3'(nb - 4'd1 - {1'b0, cj});
		cterm = ({1'b0, cj} == nb - 4'd1);
		if (!cterm) begin
			cflag = 1'b0;
			cbody = pack_slots(pay_q, {1'b0, ck, 3'b000} + 7'd8);
			clen  = 7'(cj) + 7'd1 + {1'b0, ck, 3'b000} + 7'd8;
		end else if (pay_q[7:4] == mnib) begin
			cflag = 1'b1;
			cbody = {pay_q[3:0], 60'b0};
			clen  = 7'(cj) + 7'd5;
		end else begin
			cflag = 1'b0;
			cbody = {pay_q[7:0], 56'b0};
			clen  = 7'(cj) + 7'd9;
		end
		cstream = {cbody, 16'b0} >> ({1'b0, cj} + 4'd1);
		for (int q = 0; q < 8; q++) begin
			if (4'(q) < {1'b0, cj})
				cstream[79-q] = 1'b1;
			else if (4'(q) == {1'b0, cj})
				cstream[79-q] = cflag;
		end
		if (op_q == OP_WRITE) begin
			wstream = {pack_slots(pay_q, cnt_q), 16'b0};
			wlen    = cnt_q;
		end else begin
			wstream = cstream;
			wlen    = clen;
		end
		fits = ({1'b0, wptr_q} + (PTR_W+1)'(wlen)) <= CAP_BITS;
	end

	// Status decided at command start (DECODE can still set it short).
	always_comb begin
		case (op_q)
			OP_WRITE, OP_WRITE_C: begin
				if (!((op_q == OP_WRITE) ? plain_ok : comp_ok))
					prep_st = ST_BADCOUNT;
				else if (!fits)
					prep_st = ST_OVERFLOW;
				else
					prep_st = ST_OK;
			end
			OP_READ: begin
				if (!plain_ok)
					prep_st = ST_BADCOUNT;
				else if (short_plain)
					prep_st = ST_SHORT;
				else
					prep_st = ST_OK;
			end
			OP_READ_C: begin
				if (!comp_ok)
					prep_st = ST_BADCOUNT;
				else if (avail == '0)
					prep_st = ST_SHORT;
				else
					prep_st = ST_OK;
			end
			default: prep_st = ST_OK;
		endcase
	end

	// Merge the head of the stream into the byte at the write pointer.
	always_comb begin
		woff    = wptr_q[2:0];
		wroom   = 4'd8 - {1'b0, woff};
		wtake   = (rem_q < 7'(wroom)) ? rem_q[3:0] : wroom;
		wend    = {1'b0, woff} + wtake;
		wold    = (woff != 3'd0) ? ram_rdata : 8'h00;
		wbits   = stream_q[79:72] >> woff;
		wmask   = (8'hFF >> woff) & ~(8'hFF >> wend);
		wmerged = (wold & ~wmask) | (wbits & wmask);
	end

	// Pull the next bits of the byte at the gather pointer.
	always_comb begin
		goff  = gptr_q[2:0];
		groom = 4'd8 - {1'b0, goff};
		gtake = (grem_q < 7'(groom)) ? grem_q[3:0] : groom;
		gt8   = ram_rdata << goff;
		gbits = gt8 >> (4'd8 - gtake);
	end

	// Decode a compressed code from the left-aligned window.
	always_comb begin
		dj   = '0;
		drun = 1'b1;
		for (int q = 0; q < 7; q++) begin
			if (drun && (4'(q) < nb - 4'd1) && lwin_q[79-q])
				dj = dj + 3'd1;
			else
				drun = 1'b0;
		end
		dk    = 3'(nb - 4'd1 - {1'b0, dj});
		dterm = ({1'b0, dj} == nb - 4'd1);
		dflag = lwin_q[79 - dj];
		dbody = lwin_q << ({1'b0, dj} + 4'd1);
		if (!dterm) begin
			dval = unpack_slots(dbody[79:16], {1'b0, dk, 3'b000} + 7'd8);
			dlen = 7'(dj) + 7'd1 + {1'b0, dk, 3'b000} + 7'd8;
		end else if (dflag) begin
			dval = {56'b0, mnib, dbody[79:76]};
			dlen = 7'(dj) + 7'd5;
		end else begin
			dval = {56'b0, dbody[79:72]};
			dlen = 7'(dj) + 7'd9;
		end
		for (int i = 0; i < 8; i++) begin
			if (4'(i) > {1'b0, dk} && 4'(i) < nb)
				dval[8*i +: 8] = mbyte;
		end
		dok = dlen <= gcnt_q;
	end

	always_comb begin
		ram_re    = (state_q == S_PREP) || (state_q == S_RBYTE);
		ram_raddr = (state_q == S_PREP) ? (is_wr ? wptr_q[AW+2:3] : rptr_q[AW+2:3])
		                                : gptr_q[AW+2:3] + AW'(1);
		ram_we    = (state_q == S_WBYTE);
	end

	bsp_ram #(
		.W (8),
		.D (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q[AW+2:3]),
		.wdata (wmerged),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control: state, pointers, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wptr_q      <= '0;
			rptr_q      <= '0;
			gptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					if (prep_st == ST_OK && is_wr)
						state_q <= S_WBYTE;
					else if (prep_st == ST_OK && (op_q == OP_READ || op_q == OP_READ_C))
						state_q <= S_RBYTE;
					else
						state_q <= S_DONE;
					case (op_q)
						OP_READ, OP_READ_C: gptr_q <= rptr_q;
						OP_REWIND: rptr_q <= '0;
						OP_CLEAR: begin
							rptr_q <= '0;
							wptr_q <= '0;
						end
						default: ;
					endcase
				end
				S_WBYTE: begin
					wptr_q <= wptr_q + PTR_W'(wtake);
					if (rem_q == 7'(wtake))
						state_q <= S_DONE;
				end
				S_RBYTE: begin
					gptr_q <= gptr_q + PTR_W'(gtake);
					if (grem_q == 7'(gtake))
						state_q <= S_ALIGN;
				end
				S_ALIGN: state_q <= S_DECODE;
				S_DECODE: begin
					state_q <= S_DONE;
					if (op_q == OP_READ)
						rptr_q <= rptr_q + PTR_W'(cnt_q);
					else if (dok)
						rptr_q <= rptr_q + PTR_W'(dlen);
				end
				S_DONE: begin
					if (done_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= operation;
			cnt_q <= bit_count;
			pay_q <= payload;
			uns_q <= unsigned_mode;
		end
		if (done_go) begin
			out_val_q  <= res_val_q;
			out_st_q   <= res_st_q;
			out_wpos_q <= POS_W'(wptr_q);
			out_rpos_q <= POS_W'(rptr_q);
		end
		case (state_q)
			S_PREP: begin
				res_val_q <= '0;
				res_st_q  <= prep_st;
				stream_q  <= wstream;
				rem_q     <= wlen;
				acc_q     <= '0;
				grem_q    <= (op_q == OP_READ) ? cnt_q : gsz;
				gcnt_q    <= (op_q == OP_READ) ? cnt_q : gsz;
			end
			S_WBYTE: begin
				stream_q <= stream_q << wtake;
				rem_q    <= rem_q - 7'(wtake);
			end
			S_RBYTE: begin
				acc_q  <= (acc_q << gtake) | {72'b0, gbits};
				grem_q <= grem_q - 7'(gtake);
			end
			S_ALIGN: lwin_q <= acc_q << (7'd80 - gcnt_q);
			S_DECODE: begin
				if (op_q == OP_READ)
					res_val_q <= unpack_slots(lwin_q[79:16], cnt_q);
				else if (dok)
					res_val_q <= dval;
				else
					res_st_q <= ST_SHORT;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign read_value     = out_val_q;
	assign status         = out_st_q;
	assign write_position = out_wpos_q;
	assign read_position  = out_rpos_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_checker.sv =====
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks of the bit stream packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_checker #(
	parameter int STORE_BYTES = bsp_pkg::STORE_BYTES_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [bsp_pkg::VAL_W-1:0] read_value,
	input wire logic [1:0]                status,
	input wire logic [bsp_pkg::POS_W-1:0] write_position,
	input wire logic [bsp_pkg::POS_W-1:0] read_position
);

	import bsp_pkg::*;

	// one command in flight: no transfer right after a transfer
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous command in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == '0)
		else $error("failed command returned nonzero value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status)
			&& $stable(write_position) && $stable(read_position))
		else $error("result changed while stalled");

	generate
		if (STORE_BYTES * 8 < 65536) begin : g_order
			a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
				out_valid |-> read_position <= write_position)
				else $error("read pointer passed write pointer");
		end
	endgenerate

endmodule

bind bit_stream_packer_core bsp_checker #(
	.STORE_BYTES (STORE_BYTES)
) u_bsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.read_value     (read_value),
	.status         (status),
	.write_position (write_position),
	.read_position  (read_position)
);

`default_nettype wire

// ===== verif/bit_stream_packer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_stream_packer_checker
// Watches both channels of the bit stream packer. Every command transfer is
// run through a bit-accurate model of the store and both pointers. Each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bit_stream_packer_checker
	import bsp_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic [2:0]        operation,
	input  wire logic [CNT_W-1:0]  bit_count,
	input  wire logic [VAL_W-1:0]  payload,
	input  wire logic              unsigned_mode,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [VAL_W-1:0]  read_value,
	input  wire logic [1:0]        status,
	input  wire logic [POS_W-1:0]  write_position,
	input  wire logic [POS_W-1:0]  read_position,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [1:0]       st;
		logic [POS_W-1:0] wpos;
		logic [POS_W-1:0] rpos;
	} packer_result_t;

	localparam int unsigned CAP_BITS = STORE_BYTES * 8;

	logic [7:0]     shadow_store [STORE_BYTES];
	int unsigned    wr_bit;
	int unsigned    rd_bit;
	packer_result_t predicted_q[$];

	initial begin
		errors = 0;
		foreach (shadow_store[i]) shadow_store[i] = 8'h00;
	end

	assign pending = predicted_q.size();

	function automatic void store_bit(input logic b);
		if (wr_bit / 8 < STORE_BYTES)
			shadow_store[wr_bit / 8][7 - (wr_bit % 8)] = b;
		wr_bit++;
	endfunction

	function automatic logic fetch_bit();
		logic b;
		b = 1'b0;
		if (rd_bit / 8 < STORE_BYTES)
			b = shadow_store[rd_bit / 8][7 - (rd_bit % 8)];
		rd_bit++;
		return b;
	endfunction

	// low n bits of v, MSB first
	function automatic void store_field(input logic [7:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) store_bit(v[i]);
	endfunction

	function automatic logic [7:0] fetch_field(input int n);
		logic [7:0] v;
		v = '0;
		for (int i = 0; i < n; i++) v = {v[6:0], fetch_bit()};
		return v;
	endfunction

	function automatic void store_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n / 8; i++) store_field(v[8*i +: 8], 8);
		if (n % 8 != 0) store_field(v[8*(n/8) +: 8], n % 8);
	endfunction

	function automatic logic [63:0] fetch_le(input int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n / 8; i++) v[8*i +: 8] = fetch_field(8);
		if (n % 8 != 0) v[8*(n/8) +: 8] = fetch_field(n % 8);
		return v;
	endfunction

	function automatic bit bits_left(input int unsigned n);
		return rd_bit + n <= wr_bit;
	endfunction

	// Elided-integer code; with emit clear only its length is returned.
	function automatic int unsigned code_write(input logic [63:0] v, input int nbytes,
			input logic uns, input bit emit);
		logic [7:0] fill;
		logic [3:0] nib;
		int unsigned k;
		int unsigned len;
		fill = uns ? 8'h00 : 8'hFF;
		nib  = uns ? 4'h0 : 4'hF;
		k    = nbytes - 1;
		len  = 0;
		while (k > 0) begin
			if (v[8*k +: 8] == fill) begin
				if (emit) store_bit(1'b1);
				len++;
				k--;
			end else begin
				if (emit) begin
					store_bit(1'b0);
					store_le(v, 8 * (k + 1));
				end
				return len + 1 + 8 * (k + 1);
			end
		end
		if (v[7:4] == nib) begin
			if (emit) begin
				store_bit(1'b1);
				store_field({4'h0, v[3:0]}, 4);
			end
			return len + 5;
		end
		if (emit) begin
			store_bit(1'b0);
			store_field(v[7:0], 8);
		end
		return len + 9;
	endfunction

	function automatic bit code_read(input int nbytes, input logic uns,
			output logic [63:0] v);
		logic [7:0] fill;
		logic [3:0] nib;
		logic [7:0] low;
		int unsigned k;
		fill = uns ? 8'h00 : 8'hFF;
		nib  = uns ? 4'h0 : 4'hF;
		k    = nbytes - 1;
		v    = '0;
		while (k > 0) begin
			if (!bits_left(1)) return 0;
			if (fetch_bit()) begin
				v[8*k +: 8] = fill;
				k--;
			end else begin
				if (!bits_left(8 * (k + 1))) return 0;
				v |= fetch_le(8 * (k + 1));
				return 1;
			end
		end
		if (!bits_left(1)) return 0;
		if (fetch_bit()) begin
			if (!bits_left(4)) return 0;
			low    = fetch_field(4);
			v[7:0] = {nib, low[3:0]};
		end else begin
			if (!bits_left(8)) return 0;
			v[7:0] = fetch_field(8);
		end
		return 1;
	endfunction

	function automatic packer_result_t predict_command(input logic [2:0] op,
			input logic [6:0] cnt, input logic [63:0] pay, input logic uns);
		packer_result_t r;
		bit plain_ok;
		bit code_ok;
		int unsigned saved;
		logic [63:0] v;
		r        = '0;
		plain_ok = cnt >= 1 && cnt <= 64;
		code_ok  = cnt >= 8 && cnt <= 64 && cnt[2:0] == 3'd0;
		case (op)
			OP_WRITE: begin
				if (!plain_ok) r.st = ST_BADCOUNT;
				else if (wr_bit + cnt > CAP_BITS) r.st = ST_OVERFLOW;
				else store_le(pay, cnt);
			end
			OP_READ: begin
				if (!plain_ok) r.st = ST_BADCOUNT;
				else if (!bits_left(cnt)) r.st = ST_SHORT;
				else r.value = fetch_le(cnt);
			end
			OP_WRITE_C: begin
				if (!code_ok) r.st = ST_BADCOUNT;
				else if (wr_bit + code_write(pay, cnt / 8, uns, 0) > CAP_BITS)
					r.st = ST_OVERFLOW;
				else void'(code_write(pay, cnt / 8, uns, 1));
			end
			OP_READ_C: begin
				if (!code_ok) r.st = ST_BADCOUNT;
				else begin
					saved = rd_bit;
					if (code_read(cnt / 8, uns, v)) r.value = v;
					else begin
						rd_bit = saved;
						r.st   = ST_SHORT;
					end
				end
			end
			OP_REWIND: rd_bit = 0;
			OP_CLEAR: begin
				rd_bit = 0;
				wr_bit = 0;
			end
			default: ;
		endcase
		r.wpos = wr_bit[POS_W-1:0];
		r.rpos = rd_bit[POS_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		packer_result_t exp_r;
		if (!arst_n) begin
			wr_bit = 0;
			rd_bit = 0;
			predicted_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_q.size() == 0) begin
					$display("%0t: result transfer with none expected", $realtime);
					errors++;
				end else begin
					exp_r = predicted_q.pop_front();
					if (read_value !== exp_r.value) begin
						$display("%0t: read_value expected %h actual %h",
							$realtime, exp_r.value, read_value);
						errors++;
					end
					if (status !== exp_r.st) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, exp_r.st, status);
						errors++;
					end
					if (write_position !== exp_r.wpos) begin
						$display("%0t: write_position expected %0d actual %0d",
							$realtime, exp_r.wpos, write_position);
						errors++;
					end
					if (read_position !== exp_r.rpos) begin
						$display("%0t: read_position expected %0d actual %0d",
							$realtime, exp_r.rpos, read_position);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				predicted_q.push_back(predict_command(operation, bit_count, payload,
					unsigned_mode));
		end
	end

endmodule

// ===== verif/bit_stream_packer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_stream_packer_core_tb
// Drives directed, fill-to-overflow and random command streams into the bit
// stream packer with random idling on both channels and one long output
// stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module bit_stream_packer_core_tb;
	import bsp_pkg::*;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        operation;
	logic [CNT_W-1:0]  bit_count;
	logic [VAL_W-1:0]  payload;
	logic              unsigned_mode;
	logic              out_valid;
	logic              out_ready;
	logic [VAL_W-1:0]  read_value;
	logic [1:0]        status;
	logic [POS_W-1:0]  write_position;
	logic [POS_W-1:0]  read_position;
	int                errors;
	int                pending;
	bit                idle_en;
	int                hold_req;

	bit_stream_packer_core DUT (.*);

	bit_stream_packer_checker checker_i (.*);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls plus a long hold on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= !(idle_en && $urandom_range(99) < 14);
		end
	end

	task automatic send_command(input logic [2:0] op, input logic [6:0] cnt,
			input logic [63:0] pay, input logic uns);
		bit taken;
		while (idle_en && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		bit_count     <= cnt;
		payload       <= pay;
		unsigned_mode <= uns;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// random value whose upper bytes are often all 0x00 or all 0xFF
	function automatic logic [63:0] elidable_value();
		logic [63:0] v;
		int top;
		v   = {$urandom, $urandom};
		top = $urandom_range(8);
		for (int i = 0; i < top; i++)
			v[63-8*i -: 8] = v[63] ? 8'hFF : 8'h00;
		if ($urandom_range(3) == 0) v[7:4] = v[63] ? 4'hF : 4'h0;
		return v;
	endfunction

	initial begin
		logic [2:0] op;
		logic [6:0] cnt;
		int pick;
		in_valid      = 1'b0;
		operation     = OP_WRITE;
		bit_count     = '0;
		payload       = '0;
		unsigned_mode = 1'b0;
		idle_en       = 1'b0;
		hold_req      = 0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_command(OP_READ, 7'd1, '0, 1'b0);
		send_command(OP_WRITE, 7'd0, '1, 1'b0);
		send_command(OP_WRITE, 7'd65, '1, 1'b1);
		send_command(OP_WRITE, 7'd127, '1, 1'b0);
		send_command(OP_WRITE, 7'd1, '1, 1'b0);
		send_command(OP_WRITE, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_command(OP_WRITE, 7'd13, 64'h0000_0000_0000_1ABC, 1'b0);
		send_command(OP_READ, 7'd1, '0, 1'b0);
		send_command(OP_READ, 7'd64, '0, 1'b0);
		send_command(OP_READ, 7'd64, '0, 1'b0);
		send_command(OP_READ, 7'd0, '0, 1'b0);
		send_command(OP_WRITE_C, 7'd64, 64'h0, 1'b1);
		send_command(OP_WRITE_C, 7'd64, '1, 1'b0);
		send_command(OP_WRITE_C, 7'd32, 64'h0000_0000_0000_001F, 1'b1);
		send_command(OP_WRITE_C, 7'd64, 64'h8000_0000_0000_0000, 1'b1);
		send_command(OP_WRITE_C, 7'd9, 64'h5, 1'b1);
		send_command(OP_READ_C, 7'd64, '0, 1'b1);
		send_command(OP_READ_C, 7'd64, '0, 1'b0);
		send_command(OP_READ_C, 7'd32, '0, 1'b1);
		send_command(OP_READ_C, 7'd64, '0, 1'b1);
		send_command(OP_READ_C, 7'd8, '0, 1'b1);
		send_command(OP_REWIND, 7'd5, '1, 1'b1);
		send_command(OP_SPARE6, 7'd8, '1, 1'b0);
		send_command(OP_SPARE7, 7'd8, '1, 1'b1);
		send_command(OP_CLEAR, 7'd0, '0, 1'b0);

		// fill to capacity under a long output hold, then overflow
		idle_en = 1'b1;
		hold_req++;
		for (int i = 0; i < 512; i++)
			send_command(OP_WRITE, 7'd64, {$urandom, $urandom}, 1'b0);
		send_command(OP_WRITE, 7'd1, '1, 1'b0);
		send_command(OP_WRITE_C, 7'd8, 64'h0, 1'b1);
		repeat (20) send_command(OP_READ, 7'($urandom_range(1, 64)), '0, 1'b0);
		send_command(OP_READ_C, 7'd64, '0, 1'b1);
		send_command(OP_CLEAR, 7'd0, '0, 1'b0);

		// random traffic; first stretch without idling
		idle_en = 1'b0;
		for (int i = 0; i < 250; i++) begin
			if (i == 100) idle_en = 1'b1;
			pick = $urandom_range(99);
			if (pick < 30) op = OP_WRITE;
			else if (pick < 55) op = OP_READ;
			else if (pick < 75) op = OP_WRITE_C;
			else if (pick < 92) op = OP_READ_C;
			else if (pick < 96) op = OP_REWIND;
			else if (pick < 98) op = OP_CLEAR;
			else op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
			if (op == OP_WRITE_C || op == OP_READ_C)
				cnt = 7'(8 * $urandom_range(1, 8));
			else
				cnt = 7'($urandom_range(1, 64));
			if ($urandom_range(99) < 3) cnt = 7'($urandom_range(127));
			send_command(op, cnt, elidable_value(), 1'($urandom_range(1)));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
